// ----- rtl/focus_measure_window_3x3_assert.svh -----
// Assertion macros for the focus measure block.
`ifndef FOCUS_MEASURE_WINDOW_3X3_ASSERT_SVH
`define FOCUS_MEASURE_WINDOW_3X3_ASSERT_SVH
`ifndef SYNTH
`define FM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define FM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FM_ASSERT(lbl, expr, msg)
`define FM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/fmw3_pkg.sv -----
// Shared constants and codes for the 3x3 focus measure block.
package fmw3_pkg;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 13;
  localparam int FH_W   = 16;
  localparam int THR_W  = 11;
  localparam int METH_W = 2;

  localparam logic [METH_W-1:0] METH_LAPLACIAN = 2'd0;
  localparam logic [METH_W-1:0] METH_SOBEL     = 2'd1;
  localparam logic [METH_W-1:0] METH_TENENGRAD = 2'd2;

  localparam logic [1:0] REG_METHOD    = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [METH_W-1:0] METHOD_RST    = METH_LAPLACIAN;
  localparam logic [FW_W-1:0]   WIDTH_RST     = 13'd4096;
  localparam logic [FH_W-1:0]   HEIGHT_RST    = 16'd3;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 11'd30;

endpackage

// ----- rtl/fmw3_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module fmw3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/focus_measure_window_3x3.sv -----
// Streaming 3x3 focus measure (Laplacian, Sobel L1, Tenengrad) with line store RAM.
// A pixel passes stages s1, s2, s3 and the output register; one pixel per cycle
// unless the output stalls. The line store RAM is read and written once per pixel.
// Border pixels produce no output transaction; interior pixels produce exactly one.
// Reset (rst, synchronous): registers to defaults, counters and window to zero, pipeline empty.
// The line store is not cleared; rows before two full rows of a frame are never emitted.
module focus_measure_window_3x3 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] focus_value
  output logic        m_axis_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmw3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

  // configuration
  logic [METH_W-1:0] method;
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [THR_W-1:0]  grad_threshold;
  logic [21:0]       thr_sq;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_METHOD:    prdata = 32'(method);
      REG_WIDTH:     prdata = 32'(frame_width);
      REG_HEIGHT:    prdata = 32'(frame_height);
      REG_THRESHOLD: prdata = 32'(grad_threshold);
    endcase
  end

  // geometry
  logic [WW-1:0]   fw_ext, eff_w, col_ext;
  logic [FH_W-1:0] eff_h;
  logic [AW-1:0]   col;
  logic [FH_W-1:0] row;
  logic            col_end, row_end;

  assign fw_ext  = WW'(frame_width);
  assign eff_w   = (fw_ext < WW'(3)) ? WW'(3) :
                   ((fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext);
  assign eff_h   = (frame_height < FH_W'(3)) ? FH_W'(3) : frame_height;
  assign col_ext = WW'(col);
  assign col_end = (col_ext == eff_w - WW'(1));
  assign row_end = (row == eff_h - FH_W'(1));

  // pipeline control
  logic acc;
  logic s1_v, s1_adv, s1_emit, s1_last;
  logic [7:0] s1_pix;
  logic [AW-1:0] s1_col;
  logic s2_v, s2_adv, s2_free, s2_last;
  logic s3_v, s3_adv, s3_free, s3_last;
  logic o_free;

  assign o_free        = !m_axis_tvalid || m_axis_tready;
  assign s3_adv        = s3_v && o_free;
  assign s3_free       = !s3_v || s3_adv;
  assign s2_adv        = s2_v && s3_free;
  assign s2_free       = !s2_v || s2_adv;
  assign s1_adv        = s1_v && (!s1_emit || s2_free);
  assign s_axis_tready = !s1_v || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // line store: [15:8] two rows above, [7:0] one row above
  logic        ram_re;
  logic [15:0] ram_rdata;
  logic [7:0]  top, mid;

  assign ram_re = acc;
  assign top    = ram_rdata[15:8];
  assign mid    = ram_rdata[7:0];

  fmw3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({mid, s1_pix}),
    .re    (ram_re),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // window: [0..2] column x-2 top..bottom, [3..5] column x-1 top..bottom
  logic [7:0] win [6];

  // stage 2 arithmetic
  logic [9:0]         gx_p, gx_n, gy_p, gy_n;
  logic [10:0]        nb_sum, c8;
  logic signed [12:0] gx_d, gy_d, lap_d;
  logic signed [10:0] s2_gx, s2_gy;
  logic signed [11:0] s2_lap;

  always_comb begin
    gx_p   = {2'b0, top} + {1'b0, mid, 1'b0} + {2'b0, s1_pix};
    gx_n   = {2'b0, win[0]} + {1'b0, win[1], 1'b0} + {2'b0, win[2]};
    gy_p   = {2'b0, win[2]} + {1'b0, win[5], 1'b0} + {2'b0, s1_pix};
    gy_n   = {2'b0, win[0]} + {1'b0, win[3], 1'b0} + {2'b0, top};
    nb_sum = {3'b0, win[0]} + {3'b0, win[1]} + {3'b0, win[2]} + {3'b0, win[3]}
           + {3'b0, win[5]} + {3'b0, top} + {3'b0, mid} + {3'b0, s1_pix};
    c8     = {win[4], 3'b0};
    gx_d   = $signed({3'b0, gx_p}) - $signed({3'b0, gx_n});
    gy_d   = $signed({3'b0, gy_p}) - $signed({3'b0, gy_n});
    lap_d  = $signed({2'b0, c8}) - $signed({2'b0, nb_sum});
  end

  // stage 3 arithmetic
  logic signed [10:0] gx_neg, gy_neg;
  logic signed [11:0] lap_neg;
  logic [9:0]         gx_abs, gy_abs;
  logic [10:0]        lap_abs;
  logic [10:0]        s3_lap, s3_sob;
  logic [19:0]        s3_gx2, s3_gy2;

  always_comb begin
    gx_neg  = -s2_gx;
    gy_neg  = -s2_gy;
    lap_neg = -s2_lap;
    gx_abs  = s2_gx[10] ? gx_neg[9:0] : s2_gx[9:0];
    gy_abs  = s2_gy[10] ? gy_neg[9:0] : s2_gy[9:0];
    lap_abs = s2_lap[11] ? lap_neg[10:0] : s2_lap[10:0];
  end

  // output stage
  logic [20:0] mag2;
  logic [7:0]  fv;

  always_comb begin
    mag2 = {1'b0, s3_gx2} + {1'b0, s3_gy2};
    unique case (method)
      METH_LAPLACIAN: fv = (s3_lap > 11'd255) ? 8'd255 : s3_lap[7:0];
      METH_SOBEL:     fv = {1'b0, s3_sob[10:4]};
      METH_TENENGRAD: begin
        if ({1'b0, mag2} > thr_sq) begin
          fv = (mag2[20:8] > 13'd255) ? 8'd255 : mag2[15:8];
        end else begin
          fv = 8'd0;
        end
      end
      default:        fv = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    thr_sq <= 22'(grad_threshold) * 22'(grad_threshold);
    if (rst) begin
      method         <= METHOD_RST;
      frame_width    <= WIDTH_RST;
      frame_height   <= HEIGHT_RST;
      grad_threshold <= THRESHOLD_RST;
      col            <= '0;
      row            <= '0;
      s1_v           <= 1'b0;
      s2_v           <= 1'b0;
      s3_v           <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_METHOD:    method <= pwdata[METH_W-1:0];
          REG_WIDTH: begin
            frame_width <= pwdata[FW_W-1:0];
            col         <= '0;
            row         <= '0;
          end
          REG_HEIGHT: begin
            frame_height <= pwdata[FH_W-1:0];
            col          <= '0;
            row          <= '0;
          end
          REG_THRESHOLD: grad_threshold <= pwdata[THR_W-1:0];
        endcase
      end else if (acc) begin
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : row + FH_W'(1);
        end else begin
          col <= col + AW'(1);
        end
      end

      if (s_axis_tready) begin
        s1_v <= acc;
      end
      if (s1_adv) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top;
        win[4] <= mid;
        win[5] <= s1_pix;
      end
      if (s2_free) begin
        s2_v <= s1_adv && s1_emit;
      end
      if (s3_free) begin
        s3_v <= s2_v;
      end
      if (o_free) begin
        m_axis_tvalid <= s3_v;
      end
    end

    if (acc) begin
      s1_pix  <= s_axis_tdata;
      s1_col  <= col;
      s1_emit <= (col_ext >= WW'(2)) && (row >= FH_W'(2));
      s1_last <= col_end && row_end;
    end
    if (s2_free && s1_adv && s1_emit) begin
      s2_gx   <= gx_d[10:0];
      s2_gy   <= gy_d[10:0];
      s2_lap  <= lap_d[11:0];
      s2_last <= s1_last;
    end
    if (s3_free && s2_v) begin
      s3_lap  <= lap_abs;
      s3_sob  <= {1'b0, gx_abs} + {1'b0, gy_abs};
      s3_gx2  <= 20'(gx_abs) * 20'(gx_abs);
      s3_gy2  <= 20'(gy_abs) * 20'(gy_abs);
      s3_last <= s2_last;
    end
    if (o_free && s3_v) begin
      m_axis_tdata <= fv;
      m_axis_tlast <= s3_last;
    end
  end

  `include "focus_measure_window_3x3_assert.svh"

  `FM_ASSERT(a_col_range, col_ext < eff_w, "column counter outside frame width")
  `FM_ASSERT(a_row_range, row < eff_h, "row counter outside frame height")
  `FM_ASSERT(a_ram_hold, (s1_v && !s1_adv) |-> !ram_re, "line store read while stage 1 stalled")
  `FM_ASSERT_NEXT(a_acc_fill, acc, s1_v, "accepted pixel did not reach stage 1")

endmodule

// ----- test/tb_focus_measure_window_3x3.sv -----
// Self-checking testbench for the streaming 3x3 focus measure block.
module tb_focus_measure_window_3x3;
  import fmw3_pkg::*;

  localparam int LINE_DEPTH = 4096;
  localparam int RANDOM_ITEMS = 620;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [METH_W-1:0] METH_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] focus;
    logic       last;
  } focus_result_t;

  class focus_scoreboard;
    logic [METH_W-1:0] method = METHOD_RST;
    logic [FW_W-1:0]   width = WIDTH_RST;
    logic [FH_W-1:0]   height = HEIGHT_RST;
    logic [THR_W-1:0]  thresh = THRESHOLD_RST;
    logic [7:0]        line_above [LINE_DEPTH];
    logic [7:0]        line_two_above [LINE_DEPTH];
    logic [7:0]        win [6];
    int unsigned       col = 0;
    int unsigned       row = 0;
    focus_result_t     expected_focus [$];
    int                pixels_seen = 0;
    int                checked = 0;
    int                fails = 0;

    function new();
      foreach (line_above[i]) begin
        line_above[i] = 8'd0;
        line_two_above[i] = 8'd0;
      end
      foreach (win[i]) win[i] = 8'd0;
    endfunction

    function int unsigned sat8(int unsigned v);
      return (v > 255) ? 255 : v;
    endfunction

    function int unsigned mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_METHOD: method = val[METH_W-1:0];
        REG_WIDTH: begin
          width = val[FW_W-1:0];
          col = 0;
          row = 0;
        end
        REG_HEIGHT: begin
          height = val[FH_W-1:0];
          col = 0;
          row = 0;
        end
        REG_THRESHOLD: thresh = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    task note_pixel(input logic [7:0] px);
      int unsigned w, h, x, mag2, fv;
      int t0, m0, b0, t1, m1, b1, t2, m2, b2, gx, gy, lap;
      focus_result_t r;
      w = (width < 3) ? 3 : ((width > LINE_DEPTH) ? LINE_DEPTH : width);
      h = (height < 3) ? 3 : height;
      x = (col >= w) ? 0 : col;
      pixels_seen++;

      t2 = line_two_above[x];
      m2 = line_above[x];
      b2 = px;
      line_two_above[x] = m2[7:0];
      line_above[x] = px;
      t0 = win[0]; m0 = win[1]; b0 = win[2];
      t1 = win[3]; m1 = win[4]; b1 = win[5];

      if (x >= 2 && row >= 2) begin
        gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
        gy = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
        case (method)
          METH_LAPLACIAN: begin
            lap = 8 * m1 - (t0 + t1 + t2 + m0 + m2 + b0 + b1 + b2);
            fv = sat8(mag(lap));
          end
          METH_SOBEL: fv = sat8((mag(gx) + mag(gy)) >> 4);
          METH_TENENGRAD: begin
            mag2 = gx * gx + gy * gy;
            fv = (mag2 > thresh * thresh) ? sat8(mag2 >> 8) : 0;
          end
          default: fv = 0;
        endcase
        r.focus = fv[7:0];
        r.last = (x == w - 1 && row == h - 1);
        expected_focus.push_back(r);
      end

      win[0] = t1[7:0]; win[1] = m1[7:0]; win[2] = b1[7:0];
      win[3] = t2[7:0]; win[4] = m2[7:0]; win[5] = px;

      x++;
      if (x >= w) begin
        x = 0;
        row++;
        if (row >= h) row = 0;
      end
      col = x;
    endtask

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    task check_result(input logic [7:0] fv, input logic last);
      focus_result_t e;
      if (expected_focus.size() == 0) begin
        report($sformatf("unexpected transaction focus=%0d last=%0b", fv, last));
        return;
      end
      e = expected_focus.pop_front();
      checked++;
      if (fv !== e.focus)
        report($sformatf("result %0d focus got %0d want %0d", checked, fv, e.focus));
      if (last !== e.last)
        report($sformatf("result %0d last got %0b want %0b", checked, last, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] pixel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] focus_value
  logic        m_axis_tlast;           // frame_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  focus_scoreboard sb;
  logic idling = 1'b1;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   hold_left = 0;
  int   rx_gap = 0;
  int   cycles = 0;
  int   reg_writes = 0;

  focus_measure_window_3x3 #(.MAX_WIDTH(LINE_DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL focus_measure_window_3x3");
      $finish;
    end
  end

  // result side: random stall bursts plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0 || rx_gap != 0) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      rx_gap <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] px);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drain outstanding results with the input idle, then let the pipeline clear
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_focus.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel(input int mode, input logic [7:0] base);
    case (mode)
      0: return $urandom_range(0, 255);
      1: return base + $urandom_range(0, 6);
      default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  initial begin : main
    int n, w, h, thr, mode, phases, random_sent;
    logic [7:0] base;
    phases = 0;
    random_sent = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // isolated peak and its inverse, flat field at zero threshold, full-scale vertical edge
    write_reg(REG_METHOD, METH_LAPLACIAN);
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF);
    settle();
    write_reg(REG_METHOD, METH_TENENGRAD);
    write_reg(REG_THRESHOLD, 32'd0);
    repeat (9) send_pixel(8'hFF);
    settle();
    write_reg(REG_METHOD, METH_SOBEL);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'h00 : 8'hFF);
    settle();

    // back-pressure: output held off while input keeps coming
    write_reg(REG_WIDTH, 32'd16);
    write_reg(REG_HEIGHT, 32'd6);
    holds_asked <= holds_asked + 1;
    repeat (96) send_pixel($urandom_range(0, 255));
    random_sent += 96;
    settle();

    while (random_sent < RANDOM_ITEMS) begin
      idling <= ($urandom_range(0, 3) != 0);
      write_reg(REG_METHOD, ($urandom() << METH_W) | $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: thr = 2047;
        2: thr = $urandom_range(0, 60);
        default: thr = $urandom_range(0, 1442);
      endcase
      write_reg(REG_THRESHOLD, ($urandom() << THR_W) | thr);
      if ($urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
        case ($urandom_range(0, 11))
          0: h = $urandom_range(0, 2);
          1: h = 65535;
          default: h = $urandom_range(3, 7);
        endcase
        write_reg(REG_WIDTH, ($urandom() << FW_W) | w);
        write_reg(REG_HEIGHT, ($urandom() << FH_W) | h);
        if (w < 3) w = 3;
        if (h < 3) h = 3;
        if (h == 65535) n = w * $urandom_range(3, 12);
        else n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 5) == 0) n -= $urandom_range(1, w);
      end else begin
        n = $urandom_range(5, 60);
      end
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 255);
      repeat (n) send_pixel(pick_pixel(mode, base));
      random_sent += n;
      phases++;
      settle();
    end

    // wide frame, clamped oversize width and a closing small frame, no idling
    idling <= 1'b0;
    write_reg(REG_METHOD, METH_TENENGRAD);
    write_reg(REG_THRESHOLD, $urandom_range(0, 1442));
    write_reg(REG_WIDTH, ($urandom() << FW_W) | 40);
    write_reg(REG_HEIGHT, 32'd3);
    repeat (3 * 40) send_pixel(pick_pixel(0, 8'd0));
    settle();
    write_reg(REG_METHOD, METH_SOBEL);
    write_reg(REG_WIDTH, 32'h1FFF);
    write_reg(REG_HEIGHT, $urandom_range(0, 2));
    repeat (48) send_pixel(pick_pixel(2, 8'd0));
    settle();
    write_reg(REG_METHOD, METH_UNUSED);
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd3);
    repeat (9) send_pixel(pick_pixel(0, 8'd0));
    settle();

    $display("Run covered %0d pixels, %0d focus values checked, %0d register writes, %0d random phases.",
             sb.pixels_seen, sb.checked, reg_writes, phases);
    $display("All method codes, clamped geometry, a 40-pixel-wide frame and a long output stall.");
    if (sb.fails == 0 && sb.expected_focus.size() == 0) begin
      $display("PASS focus_measure_window_3x3");
    end else begin
      $display("FAIL focus_measure_window_3x3");
    end
    $finish;
  end
endmodule
